// ----- hw/rtl/ttk_pkg.sv -----
// Package for the threshold top-k selection block: shared types, codes and defaults.
// Used by every module under hw/rtl but ttk_ram; it depends on nothing else.
package ttk_pkg;

  localparam int MAX_KEPT_DEF    = 32;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam int THR_BITS  = 16;
  localparam int RC_BITS   = 6;
  localparam int ADDR_BITS = 3;
  localparam int DATA_BITS = 32;

  localparam logic [THR_BITS-1:0] THRESHOLD_RESET    = 16'h8000;
  localparam logic [RC_BITS-1:0]  REPORT_COUNT_RESET = 6'd8;

  typedef logic [0:0] reg_idx_t;
  localparam reg_idx_t REG_THRESHOLD    = 1'b0;
  localparam reg_idx_t REG_REPORT_COUNT = 1'b1;

  typedef struct packed {
    logic [THR_BITS-1:0] threshold;
    logic [RC_BITS-1:0]  report_count;
  } cfg_t;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_CHK   = 6'b000010,
    ST_SHIFT = 6'b000100,
    ST_PLACE = 6'b001000,
    ST_FIN   = 6'b010000,
    ST_EMIT  = 6'b100000
  } state_t;

endpackage

// ----- hw/rtl/ttk_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; holds the sorted store of kept samples.
module ttk_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/ttk_cfg.sv -----
// Configuration register file behind the APB-style port: threshold and report count.
// Depends on ttk_pkg for the register codes, reset values and the cfg_t struct.
module ttk_cfg (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [ttk_pkg::ADDR_BITS-1:0]     paddr,
  input  logic [ttk_pkg::DATA_BITS-1:0]     pwdata,
  output logic [ttk_pkg::DATA_BITS-1:0]     prdata,
  output logic                              pready,
  output ttk_pkg::cfg_t                     cfg
);

  ttk_pkg::reg_idx_t reg_idx;
  logic              wr_en;

  assign reg_idx = paddr[2];
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.threshold    <= ttk_pkg::THRESHOLD_RESET;
      cfg.report_count <= ttk_pkg::REPORT_COUNT_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        ttk_pkg::REG_THRESHOLD: begin
          cfg.threshold <= pwdata[ttk_pkg::THR_BITS-1:0];
        end
        ttk_pkg::REG_REPORT_COUNT: begin
          cfg.report_count <= pwdata[ttk_pkg::RC_BITS-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // The threshold reads back sign extended, the count zero extended.
  always_comb begin
    case (reg_idx)
      ttk_pkg::REG_THRESHOLD: begin
        prdata = ttk_pkg::DATA_BITS'($signed(cfg.threshold));
      end
      ttk_pkg::REG_REPORT_COUNT: begin
        prdata = ttk_pkg::DATA_BITS'(cfg.report_count);
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

endmodule

// ----- hw/rtl/ttk_ctrl.sv -----
// Sequencer and shared comparator: threshold test, sorted insertion and readout.
// Depends on ttk_pkg; drives the store held in a ttk_ram instance.
module ttk_ctrl #(
  parameter int MAX_KEPT    = ttk_pkg::MAX_KEPT_DEF,
  parameter int SAMPLE_BITS = ttk_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  ttk_pkg::cfg_t                              cfg,
  input  logic signed [SAMPLE_BITS-1:0]              sample,
  input  logic                                       end_of_user,
  input  logic                                       sample_valid,
  output logic                                       sample_stall,
  output logic signed [SAMPLE_BITS-1:0]              value,
  output logic                                       valid_res,
  output logic                                       final_res,
  output logic                                       result_valid,
  input  logic                                       result_stall,
  output logic                                       ram_we,
  output logic [((MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1)-1:0] ram_waddr,
  output logic signed [SAMPLE_BITS-1:0]              ram_wdata,
  output logic [((MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1)-1:0] ram_raddr,
  input  logic signed [SAMPLE_BITS-1:0]              ram_rdata
);

  localparam int AW = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
  localparam int KW = $clog2(MAX_KEPT + 1);
  localparam int LW = (KW > ttk_pkg::RC_BITS) ? KW : ttk_pkg::RC_BITS;
  localparam int CW = (SAMPLE_BITS > ttk_pkg::THR_BITS) ? SAMPLE_BITS : ttk_pkg::THR_BITS;

  ttk_pkg::state_t               state, state_next;
  logic [KW-1:0]                 kept, kept_next;
  logic [AW-1:0]                 pos, pos_next;
  logic signed [SAMPLE_BITS-1:0] s_reg;
  logic                          last_reg;

  logic [LW-1:0]                 rc_w;
  logic [KW-1:0]                 lim;
  logic [KW-1:0]                 kept_c;
  logic signed [CW-1:0]          s_ext;
  logic signed [CW-1:0]          thr_ext;
  logic                          pass;
  logic                          lt;
  logic                          out_free;
  logic                          accept;
  logic                          load;
  logic signed [SAMPLE_BITS-1:0] load_value;
  logic                          load_valid;
  logic                          load_final;

  assign rc_w    = LW'(cfg.report_count);
  assign lim     = (rc_w > LW'(MAX_KEPT)) ? KW'(MAX_KEPT) : KW'(rc_w);
  assign kept_c  = (kept > lim) ? lim : kept;
  assign s_ext   = CW'(sample);
  assign thr_ext = CW'($signed(cfg.threshold));
  assign pass    = (s_ext >= thr_ext) && (lim != '0);

  // The one comparator that the full-store check and every shift step reuse.
  assign lt = ram_rdata < s_reg;

  assign out_free     = !result_valid || !result_stall;
  assign sample_stall = (state != ttk_pkg::ST_IDLE);
  assign accept       = sample_valid && (state == ttk_pkg::ST_IDLE);

  always_comb begin
    state_next = state;
    kept_next  = kept;
    pos_next   = pos;
    ram_raddr  = pos;
    ram_we     = 1'b0;
    ram_waddr  = pos;
    ram_wdata  = s_reg;
    load       = 1'b0;
    load_value = '0;
    load_valid = 1'b0;
    load_final = 1'b0;
    case (state)
      ttk_pkg::ST_IDLE: begin
        if (accept) begin
          kept_next = kept_c;
          if (!pass) begin
            state_next = ttk_pkg::ST_FIN;
          end else if (kept_c >= lim) begin
            ram_raddr  = AW'(lim - KW'(1));
            state_next = ttk_pkg::ST_CHK;
          end else if (kept_c == '0) begin
            pos_next   = '0;
            state_next = ttk_pkg::ST_PLACE;
          end else begin
            pos_next   = AW'(kept_c);
            ram_raddr  = AW'(kept_c - KW'(1));
            state_next = ttk_pkg::ST_SHIFT;
          end
        end
      end
      ttk_pkg::ST_CHK: begin
        // Full store: the sample must beat the smallest kept entry.
        if (!lt) begin
          state_next = ttk_pkg::ST_FIN;
        end else begin
          kept_next = lim - KW'(1);
          pos_next  = AW'(lim - KW'(1));
          if (lim == KW'(1)) begin
            state_next = ttk_pkg::ST_PLACE;
          end else begin
            ram_raddr  = AW'(lim - KW'(2));
            state_next = ttk_pkg::ST_SHIFT;
          end
        end
      end
      ttk_pkg::ST_SHIFT: begin
        if (lt) begin
          ram_we    = 1'b1;
          ram_waddr = pos;
          ram_wdata = ram_rdata;
          pos_next  = pos - AW'(1);
          if (pos == AW'(1)) begin
            state_next = ttk_pkg::ST_PLACE;
          end else begin
            ram_raddr = pos - AW'(2);
          end
        end else begin
          state_next = ttk_pkg::ST_PLACE;
        end
      end
      ttk_pkg::ST_PLACE: begin
        ram_we     = 1'b1;
        ram_waddr  = pos;
        ram_wdata  = s_reg;
        kept_next  = kept + KW'(1);
        state_next = ttk_pkg::ST_FIN;
      end
      ttk_pkg::ST_FIN: begin
        if (!last_reg) begin
          state_next = ttk_pkg::ST_IDLE;
        end else if (kept == '0) begin
          if (out_free) begin
            load       = 1'b1;
            load_final = 1'b1;
            state_next = ttk_pkg::ST_IDLE;
          end
        end else begin
          pos_next   = '0;
          ram_raddr  = '0;
          state_next = ttk_pkg::ST_EMIT;
        end
      end
      ttk_pkg::ST_EMIT: begin
        if (out_free) begin
          load       = 1'b1;
          load_value = ram_rdata;
          load_valid = 1'b1;
          load_final = ((KW'(pos) + KW'(1)) == kept);
          if (load_final) begin
            kept_next  = '0;
            state_next = ttk_pkg::ST_IDLE;
          end else begin
            pos_next  = pos + AW'(1);
            ram_raddr = pos + AW'(1);
          end
        end
      end
      default: begin
        state_next = ttk_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ttk_pkg::ST_IDLE;
      kept  <= '0;
      pos   <= '0;
    end else begin
      state <= state_next;
      kept  <= kept_next;
      pos   <= pos_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s_reg    <= sample;
      last_reg <= end_of_user;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      value     <= load_value;
      valid_res <= load_valid;
      final_res <= load_final;
    end
  end

`ifndef ASSERT_OFF
  a_kept_bound: assert property (@(posedge clk) disable iff (rst)
    kept <= KW'(MAX_KEPT))
    else $error("kept count exceeds store depth");

  a_no_write_on_readout: assert property (@(posedge clk) disable iff (rst)
    (state == ttk_pkg::ST_EMIT || state == ttk_pkg::ST_IDLE) |-> !ram_we)
    else $error("store written outside insertion");

  a_final_clears: assert property (@(posedge clk) disable iff (rst)
    (load && load_final) |=> (kept == '0))
    else $error("store not emptied after final result");

  a_shift_pos: assert property (@(posedge clk) disable iff (rst)
    (state == ttk_pkg::ST_SHIFT) |-> (pos != '0))
    else $error("shift step at the head of the store");
`endif

endmodule

// ----- hw/rtl/threshold_top_k_select.sv -----
// A sample below the threshold or turned away by a full store is dropped; an inserted one
// takes one store read and compare per entry moved. Input is stalled while each sample is
// handled. On an end-of-user sample the kept values then follow at one transfer per cycle
// while the receiver does not stall, largest first. Reset sets threshold to -32768, report
// count to 8 and empties the store; the store memory itself is not cleared, as only
// entries below the kept count are ever read. Top level: config, sequencer, store RAM.
module threshold_top_k_select #(
  parameter int MAX_KEPT    = ttk_pkg::MAX_KEPT_DEF,
  parameter int SAMPLE_BITS = ttk_pkg::SAMPLE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // Configuration port.
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [ttk_pkg::ADDR_BITS-1:0]     paddr,
  input  logic [ttk_pkg::DATA_BITS-1:0]     pwdata,
  output logic [ttk_pkg::DATA_BITS-1:0]     prdata,
  output logic                              pready,
  // Sample channel.
  input  logic signed [SAMPLE_BITS-1:0]     sample,
  input  logic                              end_of_user,
  input  logic                              sample_valid,
  output logic                              sample_stall,
  // Result channel.
  output logic signed [SAMPLE_BITS-1:0]     value,
  output logic                              valid_res,
  output logic                              final_res,
  output logic                              result_valid,
  input  logic                              result_stall
);

  localparam int AW = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;

  ttk_pkg::cfg_t          cfg;
  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [SAMPLE_BITS-1:0] ram_wdata;
  logic [AW-1:0]          ram_raddr;
  logic [SAMPLE_BITS-1:0] ram_rdata;

  // Threshold and report count; the user writes them only while idle, unenforced here.
  ttk_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // The sequencer keeps the store sorted in descending order. A new sample walks
  // from the tail toward the head, one entry per cycle: each step reads the entry
  // above, compares it with the sample, and moves it down one place if smaller.
  // A full store first compares against its smallest entry and drops it if beaten.
  // The result register holds a finished result while the receiver stalls, and
  // readout pauses until it is taken.
  ttk_ctrl #(
    .MAX_KEPT    (MAX_KEPT),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .sample       (sample),
    .end_of_user  (end_of_user),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .value        (value),
    .valid_res    (valid_res),
    .final_res    (final_res),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .ram_we       (ram_we),
    .ram_waddr    (ram_waddr),
    .ram_wdata    (ram_wdata),
    .ram_raddr    (ram_raddr),
    .ram_rdata    (ram_rdata)
  );

  // Sorted store of kept samples.
  ttk_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_KEPT)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

// ----- sim/tb.sv -----
// Self-checking testbench for threshold_top_k_select: samples in, ranked reports out.
// It programs the threshold and report count over the APB port and predicts each report.
// Depends on hw/rtl/ttk_pkg.sv and the threshold_top_k_select RTL.
module tb;

  localparam int SB         = ttk_pkg::SAMPLE_BITS_DEF;
  localparam int KEPT_MAX   = ttk_pkg::MAX_KEPT_DEF;
  localparam int RCB        = ttk_pkg::RC_BITS;
  // Quiet time before a register write. A dropped or inserted sample can still be
  // working through the store after the last report has come out.
  localparam int SETTLE_CYC = 2 * KEPT_MAX + 8;
  // Length of the long receiver hold-off in the backpressure test.
  localparam int LONG_HOLD  = 400;

  typedef struct {
    logic signed [SB-1:0] value;
    logic                 valid_res;
    logic                 final_res;
  } report_t;

  logic                            clk;
  logic                            rst;
  logic                            psel;
  logic                            penable;
  logic                            pwrite;
  logic [ttk_pkg::ADDR_BITS-1:0]   paddr;
  logic [ttk_pkg::DATA_BITS-1:0]   pwdata;
  logic [ttk_pkg::DATA_BITS-1:0]   prdata;
  logic                            pready;
  logic signed [SB-1:0]            sample;
  logic                            end_of_user;
  logic                            sample_valid;
  logic                            sample_stall;
  logic signed [SB-1:0]            value;
  logic                            valid_res;
  logic                            final_res;
  logic                            result_valid;
  logic                            result_stall;

  threshold_top_k_select uut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .sample       (sample),
    .end_of_user  (end_of_user),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .value        (value),
    .valid_res    (valid_res),
    .final_res    (final_res),
    .result_valid (result_valid),
    .result_stall (result_stall)
  );

  // Predictor state: our own copy of the registers and the sorted store.
  logic signed [SB-1:0] cfg_threshold;
  logic [RCB-1:0]       cfg_count;
  logic signed [SB-1:0] topk_vals [KEPT_MAX];
  int                   topk_count;

  // Reports still owed by the block, oldest first.
  report_t expected_reports [$];

  int err_count;
  // Idle percentages for the sample sender and the report receiver.
  int send_gap_pct;
  int recv_stall_pct;
  // Set by a test to make the receiver start its long hold-off.
  bit hold_req;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The run is cut off after a fixed time; a hung handshake or a missing report ends here.
  initial begin
    #50_000_000;
    $display("tb: errors");
    $finish;
  end

  // Mostly short gaps, now and then a long one, and none when pct is zero.
  function automatic int pick_gap(int pct);
    if (int'($urandom_range(99)) >= pct) return 0;
    if ($urandom_range(15) == 0) return int'($urandom_range(40, 10));
    return int'($urandom_range(3, 1));
  endfunction

  // Queues one owed report behind the others.
  task automatic owe_report(report_t r);
    expected_reports.insert(expected_reports.size(), r);
  endtask

  // Ranks one accepted sample into the predicted store. An end-of-user sample is ranked
  // first, and then the whole store is owed as reports, largest first.
  task automatic rank_sample(logic signed [SB-1:0] s, bit last);
    int      lim;
    int      pos;
    bit      keep;
    report_t r;
    lim = (cfg_count > KEPT_MAX) ? KEPT_MAX : int'(cfg_count);
    // A report count lowered mid-user trims the store to its largest entries.
    if (topk_count > lim) topk_count = lim;
    if (s >= cfg_threshold && lim != 0) begin
      keep = 1'b1;
      // With the store full, only a sample strictly above the smallest entry gets in.
      if (topk_count >= lim) begin
        if (s <= topk_vals[lim-1]) keep = 1'b0;
        else topk_count = lim - 1;
      end
      if (keep) begin
        pos = topk_count;
        while (pos > 0 && topk_vals[pos-1] < s) begin
          topk_vals[pos] = topk_vals[pos-1];
          pos--;
        end
        topk_vals[pos] = s;
        topk_count++;
      end
    end
    if (!last) return;
    if (topk_count == 0) begin
      // Nothing passed: one report marked not valid.
      r.value     = '0;
      r.valid_res = 1'b0;
      r.final_res = 1'b1;
      owe_report(r);
    end else begin
      for (int i = 0; i < topk_count; i++) begin
        r.value     = topk_vals[i];
        r.valid_res = 1'b1;
        r.final_res = (i == topk_count - 1);
        owe_report(r);
      end
    end
    topk_count = 0;
  endtask

  // Offers one sample after a random gap and waits for the transfer. Valid is left high
  // so that a following sample can go out back to back; settle lowers it.
  task automatic send_sample(logic signed [SB-1:0] s, bit last);
    int gap;
    gap = pick_gap(send_gap_pct);
    if (gap > 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample       <= s;
    end_of_user  <= last;
    sample_valid <= 1'b1;
    do @(posedge clk); while (sample_stall);
    rank_sample(s, last);
  endtask

  // Stops offering samples, waits for every owed report and then lets the block go quiet.
  task automatic settle();
    sample_valid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // Writes one register (setup then access phase), updates the predictor and reads the
  // register back. Only called while the block is quiet.
  task automatic program_reg(ttk_pkg::reg_idx_t idx, logic [ttk_pkg::DATA_BITS-1:0] data);
    logic [ttk_pkg::DATA_BITS-1:0] rd;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == ttk_pkg::REG_THRESHOLD) cfg_threshold = data[ttk_pkg::THR_BITS-1:0];
    else cfg_count = data[ttk_pkg::RC_BITS-1:0];
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    if (idx == ttk_pkg::REG_THRESHOLD && rd[ttk_pkg::THR_BITS-1:0] !== cfg_threshold) begin
      $error("threshold readback: expected %0d, got %0d", cfg_threshold,
             $signed(rd[ttk_pkg::THR_BITS-1:0]));
      err_count++;
    end
    if (idx == ttk_pkg::REG_REPORT_COUNT && rd[ttk_pkg::RC_BITS-1:0] !== cfg_count) begin
      $error("report_count readback: expected %0d, got %0d", cfg_count,
             rd[ttk_pkg::RC_BITS-1:0]);
      err_count++;
    end
  endtask

  task automatic set_config(logic signed [SB-1:0] thr, logic [RCB-1:0] rc);
    program_reg(ttk_pkg::REG_THRESHOLD,
                {{(ttk_pkg::DATA_BITS-ttk_pkg::THR_BITS){thr[ttk_pkg::THR_BITS-1]}}, thr});
    program_reg(ttk_pkg::REG_REPORT_COUNT, {{(ttk_pkg::DATA_BITS-RCB){1'b0}}, rc});
  endtask

  // A sample biased toward the threshold (ties and near misses), the field extremes,
  // or anything at all.
  function automatic logic signed [SB-1:0] pick_sample(logic signed [SB-1:0] thr);
    int v;
    case ($urandom_range(7))
      0, 1: begin
        v = int'(thr) + int'($urandom_range(8)) - 4;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return SB'(v);
      end
      2: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
      default: return SB'($urandom);
    endcase
  endfunction

  // Random users under one setting: mostly short sets, some long enough to overfill the
  // store, and a few where every sample falls below the threshold. With squeeze set, the
  // receiver holds off for a long stretch while samples keep coming.
  task automatic run_users(int n_items, logic signed [SB-1:0] thr, logic [RCB-1:0] rc,
                           int src_pct, int sink_pct, bit squeeze);
    int                   sent;
    int                   len;
    bit                   noise;
    logic signed [SB-1:0] s;
    set_config(thr, rc);
    send_gap_pct   = src_pct;
    recv_stall_pct = sink_pct;
    if (squeeze) hold_req = 1'b1;
    sent = 0;
    while (sent < n_items) begin
      len   = ($urandom_range(9) == 0) ? int'($urandom_range(40, 30))
                                       : int'($urandom_range(8, 1));
      noise = ($urandom_range(9) == 0) && (thr != 16'sh8000);
      for (int i = 0; i < len; i++) begin
        if (noise) s = SB'(-32768 + int'($urandom_range(int'(thr) + 32767)));
        else s = pick_sample(thr);
        send_sample(s, i == len - 1);
        sent++;
      end
    end
    settle();
  endtask

  // Reset values: every sample passes the lowest threshold and eight are reported.
  task automatic test_defaults();
    send_gap_pct   = 20;
    recv_stall_pct = 20;
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh0000, 1'b0);
    send_sample(-16'sd1, 1'b0);
    send_sample(16'sd100, 1'b0);
    send_sample(16'sd300, 1'b0);
    send_sample(16'sd200, 1'b0);
    send_sample(16'sd400, 1'b0);
    send_sample(16'sd500, 1'b1);
    settle();
  endtask

  // The comparison is inclusive, and a user with nothing at or above it gets one invalid report.
  task automatic test_threshold_edges();
    set_config(16'sd0, 6'd4);
    send_sample(-16'sd1, 1'b0);
    send_sample(16'sd0, 1'b0);
    send_sample(16'sd7, 1'b1);
    send_sample(-16'sd5, 1'b1);
    settle();
  endtask

  // Full store: equal values fill it, a sample equal to the smallest entry is turned
  // away, and a smaller one too.
  task automatic test_store_full();
    set_config(16'sh8000, 6'd2);
    send_sample(16'sd10, 1'b0);
    send_sample(16'sd20, 1'b0);
    send_sample(16'sd20, 1'b0);
    send_sample(16'sd20, 1'b0);
    send_sample(16'sd15, 1'b1);
    settle();
  endtask

  // A report count of zero keeps nothing, so the user reports only the invalid result.
  task automatic test_count_zero();
    set_config(16'sh8000, 6'd0);
    send_sample(16'sd100, 1'b0);
    send_sample(16'sd200, 1'b1);
    settle();
  endtask

  // The report count is lowered halfway through a user; the store keeps its largest.
  task automatic test_count_cut();
    set_config(16'sh8000, 6'd8);
    for (int i = 1; i <= 5; i++) send_sample(SB'(i), 1'b0);
    settle();
    program_reg(ttk_pkg::REG_REPORT_COUNT, 32'd2);
    send_sample(16'sd3, 1'b1);
    settle();
  endtask

  task automatic test_random_ranking();
    run_users(40, 16'sh8000, 6'd32, 0, 0, 1'b0);
    run_users(20, 16'sh7fff, 6'd1, 40, 40, 1'b0);
    // Counts above the store size saturate at its depth.
    run_users(40, SB'($urandom), 6'd63, 25, 25, 1'b0);
    run_users(30, SB'($urandom), 6'd33, 10, 30, 1'b0);
    run_users(40, SB'($urandom), RCB'($urandom_range(63)), 30, 10, 1'b0);
  endtask

  task automatic test_backpressure();
    run_users(40, SB'($urandom), 6'd32, 0, 0, 1'b1);
  endtask

  // Receiver: random stalls, or one long hold-off when a test asks for it.
  initial begin
    int burst;
    burst        = 0;
    result_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        burst    = 0;
        result_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        result_stall <= 1'b0;
      end else if (burst > 0) begin
        burst--;
      end else begin
        burst = pick_gap(recv_stall_pct);
        result_stall <= (burst > 0);
        if (burst > 0) burst--;
      end
    end
  end

  // Every report transfer is checked against the oldest owed report, field by field.
  always @(posedge clk) begin
    report_t want;
    if (!rst && result_valid && !result_stall) begin
      if (expected_reports.size() == 0) begin
        $error("unexpected report: value %0d valid_res %0b final_res %0b",
               value, valid_res, final_res);
        err_count++;
      end else begin
        want = expected_reports.pop_front();
        if (value !== want.value) begin
          $error("value: expected %0d, got %0d", want.value, value);
          err_count++;
        end
        if (valid_res !== want.valid_res) begin
          $error("valid_res: expected %0b, got %0b", want.valid_res, valid_res);
          err_count++;
        end
        if (final_res !== want.final_res) begin
          $error("final_res: expected %0b, got %0b", want.final_res, final_res);
          err_count++;
        end
      end
    end
  end

  initial begin
    err_count      = 0;
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    hold_req       = 1'b0;
    cfg_threshold  = ttk_pkg::THRESHOLD_RESET;
    cfg_count      = ttk_pkg::REPORT_COUNT_RESET;
    topk_count     = 0;
    rst            = 1'b1;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    sample         = '0;
    end_of_user    = 1'b0;
    sample_valid   = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_defaults();
    test_threshold_edges();
    test_store_full();
    test_count_zero();
    test_count_cut();
    test_random_ranking();
    test_backpressure();

    if (err_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
